@@ design/dfr_pkg.sv @@
// Shared constants and types for the length-prefixed deframer.
`timescale 1ns / 1ps
package dfr_pkg;

  localparam int unsigned FLAG_BYTES   = 4;
  localparam int unsigned HEADER_BYTES = FLAG_BYTES + 12;
  localparam int unsigned HCNT_W       = 5;

  localparam logic [7:0] ADD_KEY = 8'h86;
  localparam logic [7:0] XOR_KEY = 8'h19;

  localparam int unsigned LIMIT_W  = 21;
  localparam int unsigned CODE_W   = 32;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LIMIT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSED_CODE = 1'd1;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 21'd8192;
  localparam logic [CODE_W-1:0]  CODE_RST  = 32'd1;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_of_packet;
    logic       compressed;
    logic       oversize_error;
  } result_t;

endpackage

@@ design/obfuscated_length_prefixed_deframer.sv @@
// Top level of the obfuscated length-prefixed packet deframer.
//
//  channel  dir  handshake                         contents
//  s_axis   in   s_axis_tvalid_i / s_axis_tready_o tdata[7:0] raw_byte
//  m_axis   out  m_axis_tvalid_o / m_axis_tready_i tdata[7:0] payload_byte,
//                                                  tlast last_of_packet,
//                                                  tuser[0] compressed,
//                                                  tuser[1] oversize_error
//  cfg      in   cfg_we_i                          addr 0 payload_limit,
//                                                  addr 1 compressed_code
//
// One byte per cycle while m_axis is not stalled; a byte's result reaches m_axis
// through the input register, then the result register.
// Reset clears the packet state and loads the register defaults.
// A stalled output holds its result while one more byte waits in the input
// register; s_axis_tready_o drops only when both stages are full.
`timescale 1ns / 1ps
module obfuscated_length_prefixed_deframer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,   // [7:0] raw_byte
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [7:0]                    m_axis_tdata_o,   // [7:0] payload_byte
  output logic                          m_axis_tlast_o,
  output logic [1:0]                    m_axis_tuser_o,   // [0] compressed, [1] oversize_error
  input  logic                          cfg_we_i,
  input  logic [dfr_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [dfr_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import dfr_pkg::*;

  logic       in_valid, out_space, adv, res_valid;
  logic [7:0] in_data;
  result_t    res, out_res;

  assign adv = in_valid && out_space;

  dfr_in_reg u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .data_i  (s_axis_tdata_i),
    .valid_o (in_valid),
    .data_o  (in_data),
    .take_i  (adv)
  );

  dfr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .adv_i       (adv),
    .raw_i       (in_data),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  dfr_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .res_valid_i (res_valid),
    .res_i       (res),
    .space_o     (out_space),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .res_o       (out_res)
  );

  assign m_axis_tdata_o = out_res.payload_byte;
  assign m_axis_tlast_o = out_res.last_of_packet;
  assign m_axis_tuser_o = {out_res.oversize_error, out_res.compressed};
endmodule

@@ design/dfr_in_reg.sv @@
// Input register stage holding one raw byte.
`timescale 1ns / 1ps
module dfr_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] data_i,
  output logic       valid_o,
  output logic [7:0] data_o,
  input  logic       take_i
);
  logic       valid_q, valid_d;
  logic [7:0] data_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = (valid_i && ready_o) ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

@@ design/dfr_core.sv @@
// Descrambler, header parser and packet state with configuration registers.
`timescale 1ns / 1ps
module dfr_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dfr_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [dfr_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          adv_i,
  input  logic [7:0]                    raw_i,
  output logic                          res_valid_o,
  output dfr_pkg::result_t              res_o
);
  import dfr_pkg::*;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_SKIP    = 2'd2;

  logic [LIMIT_W-1:0] limit_q;
  logic [CODE_W-1:0]  code_q;

  logic [1:0]        phase_q, phase_d;
  logic [HCNT_W-1:0] hcnt_q, hcnt_d;
  logic [31:0]       size_q, size_d;
  logic [31:0]       marker_q, marker_d;
  logic [31:0]       rem_q, rem_d;
  logic              cmark_q, cmark_d;

  logic [7:0]        b;
  logic [31:0]       rem_dec;
  logic [HCNT_W-1:0] size_off, marker_off;
  logic [HCNT_W:0]   p_inc;
  logic [31:0]       size_nx, marker_nx, paylen;

  assign b          = (raw_i + ADD_KEY) ^ XOR_KEY;
  assign rem_dec    = rem_q - 32'd1;
  assign size_off   = hcnt_q - HCNT_W'(FLAG_BYTES);
  assign marker_off = hcnt_q - HCNT_W'(FLAG_BYTES + 8);
  assign p_inc      = {1'b0, hcnt_q} + (HCNT_W+1)'(1);
  assign paylen     = size_nx - 32'(HEADER_BYTES);

  always_comb begin
    size_nx   = size_q;
    marker_nx = marker_q;
    if (hcnt_q >= HCNT_W'(FLAG_BYTES) && hcnt_q < HCNT_W'(FLAG_BYTES + 4)) begin
      size_nx = size_q | ({24'd0, b} << {size_off[1:0], 3'd0});
    end else if (hcnt_q >= HCNT_W'(FLAG_BYTES + 8) &&
                 hcnt_q < HCNT_W'(FLAG_BYTES + 12)) begin
      marker_nx = marker_q | ({24'd0, b} << {marker_off[1:0], 3'd0});
    end
  end

  always_comb begin
    phase_d     = phase_q;
    hcnt_d      = hcnt_q;
    size_d      = size_q;
    marker_d    = marker_q;
    rem_d       = rem_q;
    cmark_d     = cmark_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (phase_q)
      PH_PAYLOAD: begin
        rem_d                = rem_dec;
        res_valid_o          = 1'b1;
        res_o.payload_byte   = b;
        res_o.last_of_packet = (rem_dec == 32'd0);
        res_o.compressed     = cmark_q;
        if (rem_dec == 32'd0) begin
          phase_d  = PH_HEADER;
          hcnt_d   = '0;
          size_d   = '0;
          marker_d = '0;
        end
      end
      PH_SKIP: begin
        rem_d = rem_dec;
        if (rem_dec == 32'd0) begin
          phase_d  = PH_HEADER;
          hcnt_d   = '0;
          size_d   = '0;
          marker_d = '0;
        end
      end
      default: begin
        size_d   = size_nx;
        marker_d = marker_nx;
        if (p_inc < (HCNT_W+1)'(HEADER_BYTES)) begin
          phase_d = PH_HEADER;
          hcnt_d  = p_inc[HCNT_W-1:0];
        end else begin
          cmark_d = (marker_nx == code_q);
          hcnt_d  = '0;
          if (size_nx <= 32'(HEADER_BYTES)) begin
            rem_d    = '0;
            phase_d  = PH_HEADER;
            size_d   = '0;
            marker_d = '0;
          end else begin
            rem_d = paylen;
            if (paylen >= {{(32-LIMIT_W){1'b0}}, limit_q}) begin
              phase_d              = PH_SKIP;
              res_valid_o          = 1'b1;
              res_o.oversize_error = 1'b1;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      hcnt_q   <= '0;
      size_q   <= '0;
      marker_q <= '0;
      rem_q    <= '0;
      cmark_q  <= 1'b0;
    end else if (adv_i) begin
      phase_q  <= phase_d;
      hcnt_q   <= hcnt_d;
      size_q   <= size_d;
      marker_q <= marker_d;
      rem_q    <= rem_d;
      cmark_q  <= cmark_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RST;
      code_q  <= CODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_PAYLOAD_LIMIT:   limit_q <= cfg_wdata_i[LIMIT_W-1:0];
        CFG_COMPRESSED_CODE: code_q  <= cfg_wdata_i[CODE_W-1:0];
        default: ;
      endcase
    end
  end
endmodule

@@ design/dfr_out_reg.sv @@
// Result register on the output stream side.
`timescale 1ns / 1ps
module dfr_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             res_valid_i,
  input  dfr_pkg::result_t res_i,
  output logic             space_o,
  output logic             valid_o,
  input  logic             ready_i,
  output dfr_pkg::result_t res_o
);
  import dfr_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign space_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q && !ready_i;
    if (adv_i) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;
endmodule

@@ design/dfr_checker.sv @@
// Port-level checks for the deframer, bound to the top level.
`timescale 1ns / 1ps
module dfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o,
  input logic [1:0] m_axis_tuser_o
);

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1]) |->
      (m_axis_tdata_o == 8'd0 && !m_axis_tlast_o && !m_axis_tuser_o[0]))
    else $error("oversize result carries data or flags");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("output valid after reset");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o) &&
       $stable(m_axis_tuser_o)))
    else $error("stalled output changed");

endmodule

bind obfuscated_length_prefixed_deframer dfr_checker u_dfr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

@@ tb/tb_obfuscated_length_prefixed_deframer.sv @@
// Self-checking testbench for the obfuscated length-prefixed packet deframer.
`timescale 1ns / 1ps
module tb_obfuscated_length_prefixed_deframer;
  import dfr_pkg::*;

  typedef enum logic [1:0] {PH_HEADER, PH_PAYLOAD, PH_SKIP} deframe_phase_e;

  // raw link byte plus an optional typed-in expectation for that transfer
  typedef struct packed {
    logic [7:0] raw;
    bit         fixed;
    bit         fixed_has;
    result_t    fixed_res;
  } link_byte_t;

  typedef struct packed {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] addr;
    logic [31:0]          value;   // register data, or total size of a packet
    logic [31:0]          marker;
    logic [7:0]           fill;
    bit                   fixed;
    bit                   fixed_has;
    result_t              fixed_res;
  } dir_row_t;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned SEND_IDLE [4] = '{0, 55, 0, 31};
  localparam int unsigned RECV_STALL [4] = '{0, 0, 55, 31};

  localparam dir_row_t DIR_TAB [20] = '{
    '{1'b0, CFG_PAYLOAD_LIMIT, 32'd0, 32'd0, 8'h00, 1'b1, 1'b0, '0},
    '{1'b0, CFG_PAYLOAD_LIMIT, 32'd16, 32'd1, 8'h00, 1'b1, 1'b0, '0},
    '{1'b0, CFG_PAYLOAD_LIMIT, 32'd17, 32'd1, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
    '{1'b0, CFG_PAYLOAD_LIMIT, 32'd17, 32'd0, 8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0}},
    '{1'b0, CFG_PAYLOAD_LIMIT, 32'd22, 32'd1, 8'h00, 1'b0, 1'b0, '0},
    '{1'b1, CFG_PAYLOAD_LIMIT, 32'd40, 32'd0, 8'h00, 1'b0, 1'b0, '0},
    '{1'b0, CFG_PAYLOAD_LIMIT, 32'd56, 32'd1, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1}},
    '{1'b0, CFG_PAYLOAD_LIMIT, 32'd55, 32'd7, 8'h00, 1'b0, 1'b0, '0},
    '{1'b1, CFG_PAYLOAD_LIMIT, 32'd1, 32'd0, 8'h00, 1'b0, 1'b0, '0},
    '{1'b0, CFG_PAYLOAD_LIMIT, 32'd17, 32'd1, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1}},
    '{1'b0, CFG_PAYLOAD_LIMIT, 32'd15, 32'd1, 8'h00, 1'b1, 1'b0, '0},
    '{1'b1, CFG_PAYLOAD_LIMIT, 32'd0, 32'd0, 8'h00, 1'b0, 1'b0, '0},
    '{1'b0, CFG_PAYLOAD_LIMIT, 32'd17, 32'd1, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1}},
    '{1'b1, CFG_PAYLOAD_LIMIT, 32'd1048576, 32'd0, 8'h00, 1'b0, 1'b0, '0},
    '{1'b1, CFG_COMPRESSED_CODE, 32'hFFFFFFFF, 32'd0, 8'h00, 1'b0, 1'b0, '0},
    '{1'b0, CFG_PAYLOAD_LIMIT, 32'd19, 32'hFFFFFFFF, 8'h00, 1'b0, 1'b0, '0},
    '{1'b0, CFG_PAYLOAD_LIMIT, 32'd17, 32'hFFFFFFFE, 8'h80, 1'b1, 1'b1,
      '{8'h80, 1'b1, 1'b0, 1'b0}},
    '{1'b1, CFG_COMPRESSED_CODE, 32'd0, 32'd0, 8'h00, 1'b0, 1'b0, '0},
    '{1'b0, CFG_PAYLOAD_LIMIT, 32'd17, 32'd0, 8'h7F, 1'b1, 1'b1, '{8'h7F, 1'b1, 1'b1, 1'b0}},
    '{1'b1, CFG_PAYLOAD_LIMIT, 32'd8192, 32'd0, 8'h00, 1'b0, 1'b0, '0}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready_o;
  logic [7:0]           s_tdata = 8'h00;
  logic                 m_tvalid_o;
  logic                 m_tready = 1'b0;
  logic [7:0]           m_tdata_o;
  logic                 m_tlast_o;
  logic [1:0]           m_tuser_o;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  link_byte_t  tx_bytes[$];
  result_t     due_results[$];
  link_byte_t  on_bus;
  link_byte_t  nxt_byte;
  bit          res_has;
  result_t     res_val;
  result_t     want;
  int unsigned send_idle = 0;
  int unsigned recv_stall = 0;
  bit          hold = 1'b0;
  int unsigned fails = 0;
  int unsigned quiet = 0;

  // predictor state and register copies
  deframe_phase_e       dp_phase;
  logic [4:0]           dp_cnt;
  logic [31:0]          dp_size;
  logic [31:0]          dp_marker;
  logic [31:0]          dp_left;
  logic                 dp_cmark;
  logic [LIMIT_W-1:0]   cf_limit;
  logic [CODE_W-1:0]    cf_code;

  obfuscated_length_prefixed_deframer uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata_o),
    .m_axis_tlast_o  (m_tlast_o),
    .m_axis_tuser_o  (m_tuser_o),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void start_hdr();
    dp_phase  = PH_HEADER;
    dp_cnt    = '0;
    dp_size   = '0;
    dp_marker = '0;
  endfunction

  function automatic void deframe_byte(input logic [7:0] raw, output bit has,
                                       output result_t res);
    logic [7:0]  b;
    int unsigned p;
    b   = (raw + ADD_KEY) ^ XOR_KEY;
    has = 1'b0;
    res = '0;
    case (dp_phase)
      PH_PAYLOAD: begin
        dp_left            = dp_left - 1;
        has                = 1'b1;
        res.payload_byte   = b;
        res.last_of_packet = (dp_left == 0);
        res.compressed     = dp_cmark;
        if (dp_left == 0) start_hdr();
      end
      PH_SKIP: begin
        dp_left = dp_left - 1;
        if (dp_left == 0) start_hdr();
      end
      default: begin
        p = dp_cnt;
        if (p >= FLAG_BYTES && p < FLAG_BYTES + 4)
          dp_size |= 32'(b) << (8 * (p - FLAG_BYTES));
        else if (p >= FLAG_BYTES + 8 && p < FLAG_BYTES + 12)
          dp_marker |= 32'(b) << (8 * (p - FLAG_BYTES - 8));
        if (p + 1 < HEADER_BYTES) begin
          dp_phase = PH_HEADER;
          dp_cnt   = 5'(p + 1);
          return;
        end
        dp_cmark = (dp_marker == cf_code);
        if (dp_size <= HEADER_BYTES) begin
          dp_left = '0;
          start_hdr();
          return;
        end
        dp_left = dp_size - HEADER_BYTES;
        dp_cnt  = '0;
        if (dp_left >= 32'(cf_limit)) begin
          dp_phase           = PH_SKIP;
          has                = 1'b1;
          res.oversize_error = 1'b1;
        end else begin
          dp_phase = PH_PAYLOAD;
        end
      end
    endcase
  endfunction

  function automatic logic [7:0] obfuscate(input logic [7:0] b);
    return (b ^ XOR_KEY) - ADD_KEY;
  endfunction

  function automatic logic [31:0] pick_size();
    int unsigned lim;
    int unsigned len;
    int unsigned r;
    lim = cf_limit;
    r   = $urandom_range(9);
    if (r < 3) return $urandom_range(HEADER_BYTES);
    if (lim < 2 || (r < 5 && lim <= 64))
      len = (lim == 0 ? 1 : lim) + $urandom_range(8);
    else
      len = 1 + $urandom_range(lim - 2 < 23 ? lim - 2 : 23);
    return HEADER_BYTES + len;
  endfunction

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(5))
      0: return 1 + $urandom_range(3);
      1: return 8 + $urandom_range(16);
      2: return 32'(LIMIT_RST);
      3: return 32'd1048576;
      4: return 32'd0;
      default: return 2 + $urandom_range(30);
    endcase
  endfunction

  task automatic send_packet(input logic [31:0] size, input logic [31:0] marker,
                             input logic [7:0] fill, input bit fixed,
                             input bit fixed_has, input result_t fixed_res);
    logic [31:0] words [3];
    int unsigned total;
    int unsigned carrier;
    logic [7:0]  raw;
    words[0] = size;
    words[1] = $urandom;
    words[2] = marker;
    total    = HEADER_BYTES + ((size > HEADER_BYTES) ? size - HEADER_BYTES : 0);
    carrier  = fixed_res.oversize_error ? HEADER_BYTES - 1 : total - 1;
    for (int unsigned k = 0; k < total; k++) begin
      if (k < FLAG_BYTES)
        raw = (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : 8'($urandom);
      else if (k < HEADER_BYTES)
        raw = obfuscate(words[(k - FLAG_BYTES) / 4][8 * ((k - FLAG_BYTES) % 4) +: 8]);
      else
        raw = obfuscate(fixed ? fill : 8'($urandom));
      tx_bytes.push_back('{raw, fixed, fixed && fixed_has && k == carrier, fixed_res});
    end
  endtask

  // header bytes give no result but for an oversize error, so allow the pipeline to settle afterwards
  task automatic drain();
    do @(negedge clk_i);
    while (tx_bytes.size() != 0 || s_tvalid || due_results.size() != 0);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (addr == CFG_PAYLOAD_LIMIT) cf_limit = data[LIMIT_W-1:0];
    else if (addr == CFG_COMPRESSED_CODE) cf_code = data;
    @(negedge clk_i);
  endtask

  task automatic random_phase(input int unsigned idle, input int unsigned stall,
                              input bit pause);
    drain();
    write_reg(CFG_PAYLOAD_LIMIT, pick_limit());
    write_reg(CFG_COMPRESSED_CODE, $urandom_range(1) ? $urandom : $urandom_range(3));
    send_idle  = idle;
    recv_stall = stall;
    while (tx_bytes.size() < 100)
      send_packet(pick_size(), $urandom_range(1) ? cf_code : $urandom, 8'h00, 1'b0,
                  1'b0, '0);
    if (pause) begin
      while (tx_bytes.size() > 50) @(negedge clk_i);
      hold = 1'b1;
      while (s_tvalid || due_results.size() != 0) @(negedge clk_i);
      hold = 1'b0;
    end
  endtask

  task automatic check_field(input string what, input logic [7:0] exp_v,
                             input logic [7:0] got);
    if (got !== exp_v) begin
      fails++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, exp_v, got);
    end
  endtask

  // input side: predict on each transfer, then present the next byte
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready_o) begin
        deframe_byte(on_bus.raw, res_has, res_val);
        if (on_bus.fixed) begin
          res_has = on_bus.fixed_has;
          res_val = on_bus.fixed_res;
        end
        if (res_has) due_results.push_back(res_val);
      end
      if (!s_tvalid || s_tready_o) begin
        if (tx_bytes.size() != 0 && !hold && $urandom_range(99) >= send_idle) begin
          nxt_byte = tx_bytes.pop_front();
          on_bus   <= nxt_byte;
          s_tdata  <= nxt_byte.raw;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready) begin
      if (due_results.size() == 0) begin
        fails++;
        $display("%0t ns: unexpected result, expected none, actual data %h last %b user %b",
                 $time, m_tdata_o, m_tlast_o, m_tuser_o);
      end else begin
        want = due_results.pop_front();
        check_field("payload_byte", want.payload_byte, m_tdata_o);
        check_field("last_of_packet", 8'(want.last_of_packet), 8'(m_tlast_o));
        check_field("compressed", 8'(want.compressed), 8'(m_tuser_o[0]));
        check_field("oversize_error", 8'(want.oversize_error), 8'(m_tuser_o[1]));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready_o) || (m_tvalid_o && m_tready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("[obfuscated_length_prefixed_deframer] ERROR");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    cf_limit = LIMIT_RST;
    cf_code  = CODE_RST;
    start_hdr();
    dp_left  = '0;
    dp_cmark = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (DIR_TAB[i]) begin
      if (DIR_TAB[i].is_cfg) begin
        drain();
        write_reg(DIR_TAB[i].addr, DIR_TAB[i].value);
      end else begin
        send_packet(DIR_TAB[i].value, DIR_TAB[i].marker, DIR_TAB[i].fill, DIR_TAB[i].fixed,
                    DIR_TAB[i].fixed_has, DIR_TAB[i].fixed_res);
      end
    end
    for (int ph = 0; ph < 4; ph++)
      random_phase(SEND_IDLE[ph % 4], RECV_STALL[ph % 4], ph == 0);
    drain();
    if (fails == 0) begin
      $display("[obfuscated_length_prefixed_deframer] OK");
    end else begin
      $display("[obfuscated_length_prefixed_deframer] ERROR");
    end
    $finish;
  end

endmodule
